FILE: rtl/hsv_pkg.sv
`timescale 1ns / 1ps
package hsv_pkg;

    localparam int CH_W      = 8;
    localparam int SAT_NUM_W = 16;  // min * 255
    localparam int HUE_NUM_W = 17;  // (sector * range + d1 - d2) * 42
    localparam int QUOT_W    = 9;   // hue quotient reaches 294
    localparam int SECT_NUM_W = 11;

    localparam logic [CH_W-1:0] HUE_STEPS  = 8'd42;
    localparam logic [CH_W-1:0] HUE_TOP    = 8'd252;
    localparam logic [CH_W-1:0] HUE_FOLD   = 8'd4;
    localparam logic [CH_W-1:0] FULL_SCALE = 8'd255;

    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } t_sector;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [CH_W-1:0] value;
        logic [CH_W-1:0] saturation;
        logic [CH_W-1:0] hue;
    } t_hsv;

    // data that rides alongside the dividers
    typedef struct packed {
        logic [CH_W-1:0] value;
        logic            sat_zero;
        logic            hue_zero;
    } t_side;

endpackage

FILE: rtl/hsv_rgb_if.sv
`timescale 1ns / 1ps
interface hsv_rgb_if;
    logic          valid;
    logic          ready;
    hsv_pkg::t_rgb data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/hsv_hsv_if.sv
`timescale 1ns / 1ps
interface hsv_hsv_if;
    logic          valid;
    logic          ready;
    hsv_pkg::t_hsv data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/rgb_to_hsv_pixel_core.sv
`timescale 1ns / 1ps
// rgb to hsv pixel converter, hue at 42 steps per sector
// pipeline of 2 front stages, 9 divider stages and 1 output stage; one item per
// cycle while o_pix.ready is high
// the dividers take one quotient bit per stage, so depth follows quotient width
// reset (synchronous, active low) clears the valid bits; payload is not reset
module rgb_to_hsv_pixel_core (
    input  logic i_clk,
    input  logic i_rst_n,
    hsv_rgb_if.sink   i_pix,
    hsv_hsv_if.source o_pix
);
    import hsv_pkg::*;

    localparam int FRONT_N = 2;
    localparam int STG_N   = FRONT_N + QUOT_W + 1;
    localparam int LAST    = STG_N - 1;

    logic [STG_N-1:0] r_vld;
    logic [STG_N-1:0] en;

    t_side                 f_side;
    logic [SAT_NUM_W-1:0]  f_sat_num;
    logic [HUE_NUM_W-1:0]  f_hue_num;
    logic [CH_W-1:0]       f_range;
    logic [QUOT_W-1:0]     q_sat, q_hue;

    t_side r_side [QUOT_W];
    t_side side_end;
    t_hsv  n_out, r_out;
    logic [CH_W-1:0] h;

    // a stage moves when it is empty or its successor moves
    always_comb begin
        en[LAST] = !r_vld[LAST] || o_pix.ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < STG_N; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_pix.ready = en[0];

    hsv_front u_front (
        .i_clk     (i_clk),
        .i_en      (en[FRONT_N-1:0]),
        .i_pix     (i_pix.data),
        .o_side    (f_side),
        .o_sat_num (f_sat_num),
        .o_hue_num (f_hue_num),
        .o_range   (f_range)
    );

    hsv_div #(
        .DIVIDEND_W (SAT_NUM_W),
        .DIVISOR_W  (CH_W),
        .QUOT_W     (QUOT_W)
    ) u_div_sat (
        .i_clk      (i_clk),
        .i_en       (en[FRONT_N +: QUOT_W]),
        .i_dividend (f_sat_num),
        .i_divisor  (f_side.value),
        .o_quot     (q_sat)
    );

    hsv_div #(
        .DIVIDEND_W (HUE_NUM_W),
        .DIVISOR_W  (CH_W),
        .QUOT_W     (QUOT_W)
    ) u_div_hue (
        .i_clk      (i_clk),
        .i_en       (en[FRONT_N +: QUOT_W]),
        .i_dividend (f_hue_num),
        .i_divisor  (f_range),
        .o_quot     (q_hue)
    );

    always_ff @(posedge i_clk) begin
        if (en[FRONT_N]) begin
            r_side[0] <= f_side;
        end
        for (int j = 1; j < QUOT_W; j++) begin
            if (en[FRONT_N + j]) begin
                r_side[j] <= r_side[j-1];
            end
        end
    end

    assign side_end = r_side[QUOT_W-1];

    always_comb begin
        h = q_hue[CH_W-1:0];
        // fold the red sector
        if (h < HUE_STEPS || h >= HUE_TOP) begin
            h = h + HUE_FOLD;
        end
        n_out.value      = side_end.value;
        n_out.saturation = side_end.sat_zero ? '0 : FULL_SCALE - q_sat[CH_W-1:0];
        n_out.hue        = side_end.hue_zero ? '0 : h;
    end

    always_ff @(posedge i_clk) begin
        if (en[LAST]) begin
            r_out <= n_out;
        end
    end

    assign o_pix.valid = r_vld[LAST];
    assign o_pix.data  = r_out;
endmodule

FILE: rtl/hsv_front.sv
`timescale 1ns / 1ps
module hsv_front (
    input  logic                           i_clk,
    input  logic [1:0]                     i_en,
    input  hsv_pkg::t_rgb                  i_pix,
    output hsv_pkg::t_side                 o_side,
    output logic [hsv_pkg::SAT_NUM_W-1:0]  o_sat_num,
    output logic [hsv_pkg::HUE_NUM_W-1:0]  o_hue_num,
    output logic [hsv_pkg::CH_W-1:0]       o_range
);
    import hsv_pkg::*;

    logic [CH_W-1:0] n_mx, n_mn, n_d1, n_d2;
    t_sector         n_sect;
    logic [CH_W-1:0] r_mx, r_mn, r_d1, r_d2;
    t_sector         r_sect;

    logic [CH_W-1:0]       range_c;
    logic [SECT_NUM_W-1:0] srange, num;
    logic [HUE_NUM_W-1:0]  num42;
    t_side                 n_side;
    t_side                 r_side;
    logic [SAT_NUM_W-1:0]  r_sat_num;
    logic [HUE_NUM_W-1:0]  r_hue_num;
    logic [CH_W-1:0]       r_range;

    // stage a: largest, smallest and dominant channel, ties go to red then green
    always_comb begin
        n_mx   = i_pix.red;
        n_mn   = i_pix.red;
        n_d1   = i_pix.green;
        n_d2   = i_pix.blue;
        n_sect = SECT_RED;
        if (i_pix.green > n_mx) begin
            n_mx   = i_pix.green;
            n_sect = SECT_GREEN;
            n_d1   = i_pix.blue;
            n_d2   = i_pix.red;
        end else begin
            n_mn = i_pix.green;
        end
        if (i_pix.blue > n_mx) begin
            n_mx   = i_pix.blue;
            n_sect = SECT_BLUE;
            n_d1   = i_pix.red;
            n_d2   = i_pix.green;
        end else if (i_pix.blue < n_mn) begin
            n_mn = i_pix.blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_mx   <= n_mx;
            r_mn   <= n_mn;
            r_d1   <= n_d1;
            r_d2   <= n_d2;
            r_sect <= n_sect;
        end
    end

    // stage b: dividends; sector offsets are 6, 2 and 4 ranges
    assign range_c = r_mx - r_mn;

    always_comb begin
        case (r_sect)
            SECT_GREEN: srange = {2'b0, range_c, 1'b0};
            SECT_BLUE:  srange = {1'b0, range_c, 2'b0};
            default:    srange = {1'b0, range_c, 2'b0} + {2'b0, range_c, 1'b0};
        endcase
        // never negative when range is nonzero
        num   = srange + SECT_NUM_W'(r_d1) - SECT_NUM_W'(r_d2);
        num42 = {1'b0, num, 5'b0} + {3'b0, num, 3'b0} + {5'b0, num, 1'b0};
        n_side.value    = r_mx;
        n_side.sat_zero = (r_mx == '0);
        n_side.hue_zero = (range_c == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_side    <= n_side;
            r_sat_num <= {r_mn, 8'b0} - SAT_NUM_W'(r_mn);
            r_hue_num <= num42;
            r_range   <= range_c;
        end
    end

    assign o_side    = r_side;
    assign o_sat_num = r_sat_num;
    assign o_hue_num = r_hue_num;
    assign o_range   = r_range;
endmodule

FILE: rtl/hsv_div.sv
`timescale 1ns / 1ps
module hsv_div #(
    parameter int DIVIDEND_W = 17,
    parameter int DIVISOR_W  = 8,
    parameter int QUOT_W     = 9
) (
    input  logic                  i_clk,
    input  logic [QUOT_W-1:0]     i_en,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic [QUOT_W-1:0]     o_quot
);
    // restoring division, one quotient bit per stage, msb first
    localparam int CMP_W = (DIVIDEND_W > DIVISOR_W + QUOT_W) ? DIVIDEND_W
                                                              : DIVISOR_W + QUOT_W;

    logic [CMP_W-1:0]     r_rem  [QUOT_W];
    logic [DIVISOR_W-1:0] r_div  [QUOT_W];
    logic [QUOT_W-1:0]    r_quot [QUOT_W];

    genvar j;
    generate
        for (j = 0; j < QUOT_W; j++) begin : g_stg
            localparam int K = QUOT_W - 1 - j;
            logic [CMP_W-1:0]     rem_in;
            logic [DIVISOR_W-1:0] div_in;
            logic [QUOT_W-1:0]    quot_in;
            logic [CMP_W-1:0]     sub;
            logic [CMP_W-1:0]     n_rem;
            logic [QUOT_W-1:0]    n_quot;

            if (j == 0) begin : g_first
                assign rem_in  = CMP_W'(i_dividend);
                assign div_in  = i_divisor;
                assign quot_in = '0;
            end else begin : g_next
                assign rem_in  = r_rem[j-1];
                assign div_in  = r_div[j-1];
                assign quot_in = r_quot[j-1];
            end

            always_comb begin
                sub    = CMP_W'(div_in) << K;
                n_rem  = rem_in;
                n_quot = quot_in;
                if (rem_in >= sub) begin
                    n_rem     = rem_in - sub;
                    n_quot[K] = 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_rem[j]  <= n_rem;
                    r_div[j]  <= div_in;
                    r_quot[j] <= n_quot;
                end
            end
        end
    endgenerate

    assign o_quot = r_quot[QUOT_W-1];
endmodule
